[src/c2c_pkg.sv]
`default_nettype none

package c2c_pkg;

  // number of micro-rotations, capped at 32
  localparam int CORDIC_STEPS = 24;
  localparam int STEPS        = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int STEP_W       = (STEPS > 1) ? $clog2(STEPS) : 1;

  // datapath widths: Q16.16 with 8 guard bits, plus growth headroom
  localparam int GUARD = 8;
  localparam int DW    = 42;
  localparam int ZW    = 64;

  localparam logic signed [ZW-1:0] PI_Q60         = 64'sh3243F6A8885A308D;
  localparam logic signed [ZW-1:0] QUARTER_PI_Q60 = 64'sh0C90FDAA22168C23;
  localparam logic signed [31:0]   PI_OUT         = 32'sd1686629713;

  // shift-subtract divide, elaboration only
  function automatic logic [63:0] cdiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q60 from the truncated power series, elaboration only
  function automatic logic signed [ZW-1:0] atan_q60(input int i);
    logic signed [ZW-1:0] sum;
    logic [63:0]          term;
    int                   k;
    sum = '0;
    if (i == 0) begin
      return QUARTER_PI_Q60;
    end
    for (k = 0; i * (2 * k + 1) <= 60; k++) begin
      term = cdiv64(64'd1 << (60 - i * (2 * k + 1)), 64'(2 * k + 1));
      if (k[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    return sum;
  endfunction

  // floor(sqrt(prod(1 + 4^-i))) in Q30, elaboration only
  function automatic logic [63:0] gain_root(input int n);
    logic [63:0] p;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bitv;
    p = 64'd1 << 60;
    for (int i = 0; i < n; i++) begin
      p = p + (p >> (2 * i));
    end
    v    = p;
    r    = '0;
    bitv = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bitv > v) begin
        bitv = bitv >> 2;
      end
    end
    for (int j = 0; j < 32; j++) begin
      if (bitv != 0) begin
        if (v >= r + bitv) begin
          v = v - (r + bitv);
          r = (r >> 1) + bitv;
        end else begin
          r = r >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return r;
  endfunction

  // inverse gain, Q32
  localparam logic [63:0] GAIN_ROOT  = gain_root(STEPS);
  localparam logic [63:0] INV_GAIN_W = (64'd1 << 62) / GAIN_ROOT;
  localparam logic [31:0] INV_GAIN   = INV_GAIN_W[31:0];

  // beat moving down the rotation chain
  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 y_zero;
    logic                 x_neg;
    logic [31:0]          height;
  } c2c_beat_t;

  // finished result
  typedef struct packed {
    logic [31:0]        radius;
    logic signed [31:0] angle;
    logic [31:0]        height;
  } c2c_res_t;

endpackage

`default_nettype wire

[src/c2c_if.sv]
`default_nettype none

// point channel
interface c2c_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  logic signed [31:0] z_coord;

  modport source (output valid, output x_coord, output y_coord, output z_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, input z_coord, output ready);
endinterface

// cylindrical result channel
interface c2c_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        radius;
  logic signed [31:0] angle;
  logic signed [31:0] height;

  modport source (output valid, output radius, output angle, output height, input ready);
  modport sink   (input valid, input radius, input angle, input height, output ready);
endinterface

`default_nettype wire

[src/c2c_prerot.sv]
`default_nettype none

module c2c_prerot
  import c2c_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire logic signed [31:0] x_coord,
  input  wire logic signed [31:0] y_coord,
  input  wire logic signed [31:0] z_coord,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output c2c_beat_t               dn_beat
);

  logic                 v_r;
  c2c_beat_t            b_r;
  c2c_beat_t            b_nxt;
  logic                 en;
  logic signed [DW-1:0] xg;
  logic signed [DW-1:0] yg;

  assign en       = !v_r || dn_ready;
  assign up_ready = en;
  assign dn_valid = v_r;
  assign dn_beat  = b_r;

  // add guard bits, fold left half-plane onto the right
  always_comb begin
    xg = {{(DW-40){x_coord[31]}}, x_coord, 8'h00};
    yg = {{(DW-40){y_coord[31]}}, y_coord, 8'h00};
    b_nxt.y_zero = (y_coord == 32'sd0);
    b_nxt.x_neg  = x_coord[31];
    b_nxt.height = z_coord;
    if (x_coord[31]) begin
      b_nxt.x = -xg;
      b_nxt.y = -yg;
      b_nxt.z = y_coord[31] ? -PI_Q60 : PI_Q60;
    end else begin
      b_nxt.x = xg;
      b_nxt.y = yg;
      b_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      b_r <= b_nxt;
    end
  end

endmodule

`default_nettype wire

[src/c2c_cell.sv]
`default_nettype none

module c2c_cell
  import c2c_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [STEP_W-1:0]       step_idx,
  input  wire logic signed [ZW-1:0]    atan_c,
  input  wire logic                    up_valid,
  output logic                         up_ready,
  input  wire c2c_beat_t               up_beat,
  output logic                         dn_valid,
  input  wire logic                    dn_ready,
  output c2c_beat_t                    dn_beat
);

  logic                 v_r;
  c2c_beat_t            b_r;
  c2c_beat_t            b_nxt;
  logic                 en;
  logic signed [DW-1:0] xi;
  logic signed [DW-1:0] yi;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;

  assign en       = !v_r || dn_ready;
  assign up_ready = en;
  assign dn_valid = v_r;
  assign dn_beat  = b_r;

  // one micro-rotation toward y = 0
  always_comb begin
    xi    = up_beat.x;
    yi    = up_beat.y;
    dx    = yi >>> step_idx;
    dy    = xi >>> step_idx;
    b_nxt = up_beat;
    if (!yi[DW-1]) begin
      b_nxt.x = xi + dx;
      b_nxt.y = yi - dy;
      b_nxt.z = up_beat.z + atan_c;
    end else begin
      b_nxt.x = xi - dx;
      b_nxt.y = yi + dy;
      b_nxt.z = up_beat.z - atan_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      b_r <= b_nxt;
    end
  end

endmodule

`default_nettype wire

[src/c2c_post.sv]
`default_nettype none

module c2c_post
  import c2c_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      up_valid,
  output logic           up_ready,
  input  wire c2c_beat_t up_beat,
  output logic           dn_valid,
  input  wire logic      dn_ready,
  output c2c_res_t       dn_res
);

  logic               v1_r;
  logic               v2_r;
  logic               en1;
  logic               en2;
  logic [63:0]        plo_r;
  logic [63:0]        plo_nxt;
  logic [40:0]        phi_r;
  logic [40:0]        phi_nxt;
  logic signed [31:0] ang_r;
  logic signed [31:0] ang_nxt;
  logic [31:0]        hgt_r;
  c2c_res_t           res_r;
  c2c_res_t           res_nxt;
  logic [40:0]        xf;
  logic signed [ZW-1:0] zr;
  logic signed [ZW-1:0] zs;
  logic [73:0]        sum;

  assign en2      = !v2_r || dn_ready;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;
  assign dn_valid = v2_r;
  assign dn_res   = res_r;

  // stage 1: angle round and clamp, radius partial products
  always_comb begin
    xf      = up_beat.x[DW-1] ? '0 : up_beat.x[40:0];
    plo_nxt = xf[31:0] * INV_GAIN;
    phi_nxt = xf[40:32] * INV_GAIN;
    zr      = up_beat.z + (64'sd1 <<< 30);
    zs      = zr >>> 31;
    if (up_beat.y_zero) begin
      ang_nxt = up_beat.x_neg ? PI_OUT : 32'sd0;
    end else if (zs > 64'(PI_OUT)) begin
      ang_nxt = PI_OUT;
    end else if (zs < -64'(PI_OUT)) begin
      ang_nxt = -PI_OUT;
    end else begin
      ang_nxt = zs[31:0];
    end
  end

  // stage 2: sum partials, round, saturate
  always_comb begin
    sum = 74'({phi_r, 32'h0}) + 74'(plo_r) + (74'd1 << 39);
    res_nxt.radius = (|sum[73:72]) ? 32'hFFFF_FFFF : sum[71:40];
    res_nxt.angle  = ang_r;
    res_nxt.height = hgt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= up_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && up_valid) begin
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
      ang_r <= ang_nxt;
      hgt_r <= up_beat.height;
    end
    if (en2 && v1_r) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

[src/cartesian_to_cylindrical_core.sv]
// channel   dir  payload                                                   handshake
// in_ch     in   x_coord, y_coord, z_coord (s Q16.16)                      valid/ready
// out_ch    out  radius (u Q16.16), angle (s rad*2^29), height (s Q16.16)  valid/ready
//
// one point per clock while out_ch is not stalled; the pipeline is a pre-rotation stage,
// one rotation cell per CORDIC step and two output stages for the gain multiply
// every stage holds its own valid bit, so bubbles collapse under back-pressure
// and a new point is taken while a finished result waits in the output register
// rst_n clears the valid bits only; the datapath registers are not reset
`default_nettype none

module cartesian_to_cylindrical_core
  import c2c_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  c2c_in_if.sink    in_ch,
  c2c_out_if.source out_ch
);

  c2c_beat_t  beat [STEPS+1];
  logic [STEPS:0] vld;
  logic [STEPS:0] rdy;
  logic       post_rdy;
  c2c_res_t   res;

  // quadrant fold
  c2c_prerot u_prerot (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .x_coord  (in_ch.x_coord),
    .y_coord  (in_ch.y_coord),
    .z_coord  (in_ch.z_coord),
    .dn_valid (vld[0]),
    .dn_ready (rdy[0]),
    .dn_beat  (beat[0])
  );

  // rotation chain
  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    localparam logic signed [ZW-1:0] ATAN_C = atan_q60(g);
    c2c_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step_idx (STEP_W'(g)),
      .atan_c   (ATAN_C),
      .up_valid (vld[g]),
      .up_ready (rdy[g]),
      .up_beat  (beat[g]),
      .dn_valid (vld[g+1]),
      .dn_ready (rdy[g+1]),
      .dn_beat  (beat[g+1])
    );
  end

  assign rdy[STEPS] = post_rdy;

  // gain compensation and angle finish
  c2c_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (vld[STEPS]),
    .up_ready (post_rdy),
    .up_beat  (beat[STEPS]),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_res   (res)
  );

  assign out_ch.radius = res.radius;
  assign out_ch.angle  = res.angle;
  assign out_ch.height = res.height;

  // checks
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld[0])
    else $error("accepted beat missing from pre-rotation stage");

  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld[STEPS] && !rdy[STEPS] |=> vld[STEPS])
    else $error("last rotation cell dropped a stalled beat");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.angle <= PI_OUT) && (out_ch.angle >= -PI_OUT))
    else $error("angle outside +-pi");

endmodule

`default_nettype wire
